// File: src/plr_pkg.sv
// Package for the permutation rank block: sizes, factorial table,
// queue entry type and configuration register indexes.
// No dependencies.
`default_nettype none

package plr_pkg;

  localparam int MAX_SIZE  = 16;
  localparam int VAL_W     = 4;
  localparam int SIZE_W    = 5;
  localparam int POS_W     = $clog2(MAX_SIZE);
  localparam int CNT_W     = $clog2(MAX_SIZE);
  localparam int FACT_W    = 41;
  localparam int RANK_W    = 45;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;
  localparam int ADDR_W    = 3;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  localparam logic CFG_IDX_PERM_SIZE = 1'b0;

  // k! for k = 0 .. MAX_SIZE-1.
  localparam logic [FACT_W-1:0] FACT_TAB [MAX_SIZE] = '{
    41'd1, 41'd1, 41'd2, 41'd6, 41'd24, 41'd120, 41'd720, 41'd5040,
    41'd40320, 41'd362880, 41'd3628800, 41'd39916800, 41'd479001600,
    41'd6227020800, 41'd87178291200, 41'd1307674368000
  };

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] idx;
    logic             err;
    logic             last;
  } q_entry_t;

endpackage

`default_nettype wire

// File: src/plr_fifo.sv
// Short queue between the classifying front end and the accumulating back end.
// Depends on plr_pkg for the entry type and depth.
`default_nettype none

module plr_fifo import plr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     flush,
  input  wire logic     wr_en,
  input  wire q_entry_t wr_data,
  input  wire logic     rd_en,
  output q_entry_t      rd_data,
  output logic          full,
  output logic          empty
);

  q_entry_t              mem_r [QDEPTH];
  logic [QAW-1:0]        wr_ptr_r;
  logic [QAW-1:0]        rd_ptr_r;
  logic [QAW:0]          count_r;
  logic [QAW:0]          count_nxt;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (!flush && wr_en && !rd_en) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a lone write");

endmodule

`default_nettype wire

// File: src/plr_front.sv
// Front end: accepts elements, tracks seen values and position, and queues
// the unused-below count, factorial index, error flag and last flag of each element.
// Depends on plr_pkg.
`default_nettype none

module plr_front import plr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  clr,
  input  wire logic [SIZE_W-1:0]     n_size,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  q_full,
  output logic                       q_push,
  output q_entry_t                   q_entry
);

  logic [MAX_SIZE-1:0] seen_r;
  logic [MAX_SIZE-1:0] seen_nxt;
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    pos_nxt;
  logic [VAL_W-1:0]    val;
  logic [MAX_SIZE-1:0] bit_vec;
  logic [MAX_SIZE-1:0] below_free;
  logic                out_of_range;
  logic                repeated;
  logic                good;
  logic                last;
  logic [CNT_W-1:0]    cnt;

  assign in_tready    = !q_full;
  assign q_push       = in_tvalid && in_tready;
  assign val          = in_tdata[VAL_W-1:0];
  assign bit_vec      = MAX_SIZE'(1) << val;
  assign out_of_range = (SIZE_W'(val) >= n_size);
  assign repeated     = |(seen_r & bit_vec);
  assign good         = !out_of_range && !repeated;
  assign below_free   = ~seen_r & (bit_vec - MAX_SIZE'(1));
  assign last         = (SIZE_W'(pos_r) == (n_size - SIZE_W'(1)));

  always_comb begin
    cnt = '0;
    for (int i = 0; i < MAX_SIZE; i++) begin
      cnt = cnt + CNT_W'(below_free[i]);
    end
  end

  always_comb begin
    q_entry.cnt  = good ? cnt : '0;
    q_entry.idx  = POS_W'(n_size - SIZE_W'(1) - SIZE_W'(pos_r));
    q_entry.err  = !good;
    q_entry.last = last;
  end

  always_comb begin
    seen_nxt = seen_r;
    pos_nxt  = pos_r;
    if (q_push) begin
      if (last) begin
        seen_nxt = '0;
        pos_nxt  = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (good) begin
          seen_nxt = seen_r | bit_vec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      seen_r <= '0;
      pos_r  <= '0;
    end else begin
      seen_r <= seen_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/plr_back.sv
// Back end: multiplies each queued count by its factorial, accumulates the
// rank and error flag, and holds the finished result in an output register.
// Depends on plr_pkg.
`default_nettype none

module plr_back import plr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   clr,
  input  wire logic                   q_empty,
  input  wire q_entry_t               q_entry,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_DATA_W-1:0]       out_tdata,
  output logic                        out_tuser
);

  logic [RANK_W-1:0] rank_r;
  logic              err_r;
  logic              out_valid_r;
  logic [RANK_W-1:0] out_rank_r;
  logic              out_err_r;
  logic [FACT_W-1:0] fact_val;
  logic [RANK_W-1:0] prod;
  logic [RANK_W-1:0] sum;
  logic              err_sum;

  assign q_pop      = !q_empty && (!out_valid_r || out_tready);
  assign fact_val   = FACT_TAB[q_entry.idx];
  assign prod       = RANK_W'(fact_val) * RANK_W'(q_entry.cnt);
  assign sum        = rank_r + prod;
  assign err_sum    = err_r | q_entry.err;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-RANK_W)'(0), out_rank_r};
  assign out_tuser  = out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      rank_r <= '0;
      err_r  <= 1'b0;
    end else if (q_pop) begin
      if (q_entry.last) begin
        rank_r <= '0;
        err_r  <= 1'b0;
      end else begin
        rank_r <= sum;
        err_r  <= err_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && q_entry.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.last) begin
      out_rank_r <= sum;
      out_err_r  <= err_sum;
    end
  end

endmodule

`default_nettype wire

// File: src/permutation_lex_rank.sv
// Top level: lexicographic rank of a permutation fed one element per transfer.
// Throughput is one element per cycle while the four-entry queue is not full.
// The rank is loaded into the output register when the last element leaves the queue;
// a stalled output holds the queue.
// Synchronous reset clears all progress and sets perm_size to 16.
// Depends on plr_pkg, plr_front, plr_fifo and plr_back.
`default_nettype none

module permutation_lex_rank import plr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_DATA_W-1:0]   in_tdata,   // [3:0] element_value
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_DATA_W-1:0]       out_tdata,  // [44:0] perm_rank
  output logic                        out_tuser,  // [0] bad_input
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [ADDR_W-1:0]      cfg_paddr,
  input  wire logic [31:0]            cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic [SIZE_W-1:0] perm_size_r;
  logic [SIZE_W-1:0] n_size;
  logic              cfg_sel_size;
  logic              cfg_wr;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  q_entry_t          q_wr_entry;
  q_entry_t          q_rd_entry;

  assign cfg_pready   = 1'b1;
  assign cfg_sel_size = (cfg_paddr[ADDR_W-1] == CFG_IDX_PERM_SIZE);
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                        && cfg_sel_size;
  assign cfg_prdata   = cfg_sel_size ? 32'(perm_size_r) : 32'd0;

  always_comb begin
    if (perm_size_r < SIZE_MIN) begin
      n_size = SIZE_MIN;
    end else if (perm_size_r > SIZE_MAX) begin
      n_size = SIZE_MAX;
    end else begin
      n_size = perm_size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_size_r <= SIZE_RESET;
    end else if (cfg_wr) begin
      perm_size_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  plr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_wr),
    .n_size    (n_size),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wr_entry)
  );

  plr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .flush   (cfg_wr),
    .wr_en   (q_push),
    .wr_data (q_wr_entry),
    .rd_en   (q_pop),
    .rd_data (q_rd_entry),
    .full    (q_full),
    .empty   (q_empty)
  );

  plr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (cfg_wr),
    .q_empty    (q_empty),
    .q_entry    (q_rd_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// File: tb/plr_rank_checker.sv
// Checker for permutation_lex_rank: tracks the element, result and register transfers,
// predicts the rank and the bad-input flag, and compares each result in order.
// Depends on plr_pkg.
`timescale 1ns / 1ps

module plr_rank_checker import plr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  out_tuser,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [ADDR_W-1:0]     cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  input  wire logic                  cfg_pready,
  output int                         ranks_pending,
  output int                         fail_count
);

  typedef struct {
    bit [RANK_W-1:0] rank;
    bit              bad;
  } rank_result_t;

  rank_result_t      rank_q[$];
  rank_result_t      oldest;
  bit [SIZE_W-1:0]   size_reg;
  bit [MAX_SIZE-1:0] used_vals;
  int unsigned       elem_pos;
  bit [RANK_W-1:0]   rank_acc;
  bit                bad_acc;
  int                mismatches = 0;

  initial begin
    ranks_pending = 0;
    fail_count = 0;
  end

  function automatic longint unsigned factorial(input int unsigned k);
    longint unsigned f;
    f = 1;
    for (int unsigned i = 2; i <= k; i++) f = f * i;
    return f;
  endfunction

  function automatic int unsigned active_size(input bit [SIZE_W-1:0] s);
    if (s < 2) return 2;
    if (s > MAX_SIZE) return MAX_SIZE;
    return s;
  endfunction

  function void clear_progress();
    used_vals = '0;
    elem_pos = 0;
    rank_acc = '0;
    bad_acc = 1'b0;
  endfunction

  // Adds the contribution of one element; pushes a result once the permutation is complete.
  function void rank_element(input bit [VAL_W-1:0] v);
    int unsigned n;
    int unsigned lower;
    rank_result_t done;
    n = active_size(size_reg);
    if (elem_pos >= n) elem_pos = n - 1;
    if (v >= n || used_vals[v]) begin
      bad_acc = 1'b1;
    end else begin
      lower = 0;
      for (int i = 0; i < v; i++) if (!used_vals[i]) lower++;
      rank_acc = rank_acc + RANK_W'(lower * factorial(n - 1 - elem_pos));
      used_vals[v] = 1'b1;
    end
    elem_pos++;
    if (elem_pos >= n) begin
      done.rank = rank_acc;
      done.bad = bad_acc;
      rank_q.push_back(done);
      clear_progress();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      size_reg = SIZE_RESET;
      clear_progress();
      rank_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          (cfg_paddr >> 2) == ADDR_W'(CFG_IDX_PERM_SIZE)) begin
        size_reg = cfg_pwdata[SIZE_W-1:0];
        clear_progress();
      end
      if (out_tvalid && out_tready) begin
        if (rank_q.size() == 0) begin
          $display("%0t: result transfer with none expected: rank %0d, bad_input %0b",
                   $time, out_tdata[RANK_W-1:0], out_tuser);
          mismatches++;
        end else begin
          oldest = rank_q.pop_front();
          if (out_tdata[RANK_W-1:0] != oldest.rank) begin
            $display("%0t: perm_rank mismatch: expected %0d, actual %0d",
                     $time, oldest.rank, out_tdata[RANK_W-1:0]);
            mismatches++;
          end
          if (out_tuser != oldest.bad) begin
            $display("%0t: bad_input mismatch: expected %0b, actual %0b",
                     $time, oldest.bad, out_tuser);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) rank_element(in_tdata[VAL_W-1:0]);
    end
    ranks_pending <= rank_q.size();
    fail_count <= mismatches;
  end

endmodule

// File: tb/permutation_lex_rank_tb.sv
// Testbench top for permutation_lex_rank: clock, reset, element and register stimulus
// under several idle and stall patterns, a watchdog and the final verdict.
// Depends on plr_pkg, plr_rank_checker and the block's RTL.
`timescale 1ns / 1ps

module permutation_lex_rank_tb;
  import plr_pkg::*;

  localparam int TOTAL_ITEMS    = 550;
  localparam int PHASE_ITEMS    = 45;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [ADDR_W-1:0] PERM_SIZE_ADDR = ADDR_W'(4 * int'(CFG_IDX_PERM_SIZE));
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR  = ADDR_W'(4 * (int'(CFG_IDX_PERM_SIZE) + 1));

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]     cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int ranks_pending;
  int fail_count;
  int items_sent = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  permutation_lex_rank DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  plr_rank_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .ranks_pending (ranks_pending),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("permutation_lex_rank_tb NOT OK");
      $finish;
    end
  end

  // The valid is left high after a transfer so back-to-back items go without a gap.
  task automatic send_elem(input bit [VAL_W-1:0] v);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'(v);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ranks_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed permutations; the rest carry a repeat, an out-of-range value,
  // random noise, or stop short so the next permutation starts mid-way.
  task automatic send_perm(input int unsigned n);
    bit [VAL_W-1:0] order [MAX_SIZE];
    bit [VAL_W-1:0] tmp;
    int unsigned j;
    int unsigned a;
    int unsigned b;
    int unsigned len;
    int unsigned kind;
    for (int i = 0; i < MAX_SIZE; i++) order[i] = VAL_W'(i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    len = n;
    kind = $urandom_range(99);
    a = $urandom_range(n - 1);
    b = (a + $urandom_range(n - 1, 1)) % n;
    if (kind >= 96) begin
      len = $urandom_range(n - 1, 1);
    end else if (kind >= 92) begin
      for (int i = 0; i < n; i++) order[i] = VAL_W'($urandom_range(MAX_SIZE - 1));
    end else if (kind >= 86 && n < MAX_SIZE) begin
      order[a] = VAL_W'($urandom_range(MAX_SIZE - 1, n));
    end else if (kind >= 80) begin
      order[a] = order[b];
    end
    for (int i = 0; i < len; i++) send_elem(order[i]);
  endtask

  initial begin
    int phase;
    int phase_end;
    int unsigned perm_len;
    int unsigned wval;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: largest rank at the reset size, then small sizes with a
    // repeated value, an out-of-range value and an abandoned permutation.
    for (int v = MAX_SIZE - 1; v >= 0; v--) send_elem(VAL_W'(v));
    settle();
    cfg_write(PERM_SIZE_ADDR, 32'd2);
    send_elem(4'd1);
    send_elem(4'd0);
    settle();
    cfg_write(PERM_SIZE_ADDR, 32'd3);
    send_elem(4'd2);
    send_elem(4'd2);
    send_elem(4'd0);
    send_elem(4'd5);
    send_elem(4'd0);
    send_elem(4'd1);
    send_elem(4'd1);
    settle();
    cfg_write(PERM_SIZE_ADDR, 32'd3);
    send_elem(4'd0);
    send_elem(4'd1);
    send_elem(4'd2);
    perm_len = 3;

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      settle();
      case (phase % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_gap_pct = 47;
          stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct = 47;
        end
        default: begin
          send_gap_pct = 7;
          stall_pct = 7;
        end
      endcase
      if (phase > 1 && $urandom_range(3) == 0) begin
        cfg_write(UNMAPPED_ADDR, $urandom);
      end else begin
        if (phase == 0) perm_len = MAX_SIZE;
        else if (phase == 1) perm_len = 2;
        else if ($urandom_range(9) == 0) perm_len = 2;
        else if ($urandom_range(9) == 0) perm_len = MAX_SIZE;
        else perm_len = $urandom_range(MAX_SIZE - 1, 2);
        wval = perm_len;
        if (perm_len == 2 && $urandom_range(1) == 1) wval = $urandom_range(1);
        if (perm_len == MAX_SIZE && $urandom_range(1) == 1) wval = $urandom_range(31, MAX_SIZE + 1);
        cfg_write(PERM_SIZE_ADDR, {27'($urandom), 5'(wval)});
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_perm(perm_len);
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("permutation_lex_rank_tb OK");
    end else begin
      $display("permutation_lex_rank_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
src/plr_pkg.sv
src/plr_fifo.sv
src/plr_front.sv
src/plr_back.sv
src/permutation_lex_rank.sv
tb/plr_rank_checker.sv
tb/permutation_lex_rank_tb.sv
